@@ design/sdrnn_pkg.sv @@
package sdrnn_pkg;

    localparam int VALUE_BITS     = 16;
    localparam int FRAC_BITS      = 11;
    localparam int DECAY_BITS     = 16;
    localparam int BATCH_IDX_BITS = 2;
    localparam int DIM_IDX_BITS   = 8;

    localparam logic [DECAY_BITS-1:0] DECAY_RESET = 16'd16384;

    typedef enum logic [1:0] {
        OP_LOAD_BIAS   = 2'd0,
        OP_LOAD_HIDDEN = 2'd1,
        OP_STEP        = 2'd2
    } t_op;

    typedef logic signed [VALUE_BITS-1:0] t_value;

    // one step transaction entering the gating pipeline
    typedef struct packed {
        logic [BATCH_IDX_BITS-1:0] b;
        logic [DIM_IDX_BITS-1:0]   d;
        t_value                    h;
        logic                      sat;
        logic                      last;
    } t_gate_in;

    typedef struct packed {
        logic [BATCH_IDX_BITS-1:0] out_batch;
        logic [DIM_IDX_BITS-1:0]   out_dim;
        t_value                    hidden;
        t_value                    gated;
        logic                      saturated;
        logic                      last;
    } t_result;

    typedef struct packed {
        logic s4;
        logic s5;
    } t_gate_busy;

endpackage

@@ design/sdrnn_if.sv @@
interface sdrnn_in_if;
    logic                                    valid;
    logic                                    ready;
    logic [1:0]                              operation;
    logic [sdrnn_pkg::BATCH_IDX_BITS-1:0]    batch_index;
    logic [sdrnn_pkg::DIM_IDX_BITS-1:0]      dim_index;
    logic signed [sdrnn_pkg::VALUE_BITS-1:0] value;
    logic                                    end_of_sequence;

    modport source (
        output valid, operation, batch_index, dim_index, value, end_of_sequence,
        input  ready
    );
    modport sink (
        input  valid, operation, batch_index, dim_index, value, end_of_sequence,
        output ready
    );
endinterface

interface sdrnn_out_if;
    logic                                    valid;
    logic                                    ready;
    logic [sdrnn_pkg::BATCH_IDX_BITS-1:0]    out_batch;
    logic [sdrnn_pkg::DIM_IDX_BITS-1:0]      out_dim;
    logic signed [sdrnn_pkg::VALUE_BITS-1:0] hidden;
    logic signed [sdrnn_pkg::VALUE_BITS-1:0] gated;
    logic                                    saturated;
    logic                                    last;

    modport source (
        output valid, out_batch, out_dim, hidden, gated, saturated, last,
        input  ready
    );
    modport sink (
        input  valid, out_batch, out_dim, hidden, gated, saturated, last,
        output ready
    );
endinterface

@@ design/scalar_decay_rnn_forward_top.sv @@
// a step transaction goes through stages 1 to 3, gate stages 4 and 5 and the output fifo to the result channel
// throughput: one transaction per cycle while ready is high; a step that reads the hidden or bias
//   entry written by the stage 1 transaction waits until that write reaches stage 2 (memory write-back)
// results queue in an 8-entry output fifo; input stalls once 8 steps are in flight or queued
// reset: decay returns to 0.5, then a sweep over all BATCHES*DIMS hidden entries zeroes both memories
//   with the input held not ready; config writes are taken during the sweep
module scalar_decay_rnn_forward_top #(
    parameter int BATCHES = 4,
    parameter int DIMS    = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    sdrnn_in_if.sink                            i_item,
    sdrnn_out_if.source                         o_result,
    input  logic                                i_cfg_we,
    input  logic [sdrnn_pkg::DECAY_BITS-1:0]    i_cfg_wdata
);

    localparam int ENTRIES    = BATCHES * DIMS;
    localparam int AW         = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int DW         = (DIMS > 1) ? $clog2(DIMS) : 1;
    localparam int BI_W       = sdrnn_pkg::BATCH_IDX_BITS;
    localparam int DI_W       = sdrnn_pkg::DIM_IDX_BITS;
    localparam int FIFO_DEPTH = 8;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = PTR_W + 1;
    localparam int P_W        = 34;
    localparam logic signed [P_W-1:0] H_HALF = 34'sd16384;

    // index reduction tables, built at elaboration
    logic [BI_W-1:0] bat_mod [2**BI_W];
    logic [DI_W-1:0] dim_mod [2**DI_W];

    for (genvar i = 0; i < 2**BI_W; i++) begin : g_bat_mod
        localparam int BM = i % BATCHES;
        assign bat_mod[i] = BI_W'(BM);
    end
    for (genvar i = 0; i < 2**DI_W; i++) begin : g_dim_mod
        localparam int DM = i % DIMS;
        assign dim_mod[i] = DI_W'(DM);
    end

    logic signed [15:0] r_hid_mem  [ENTRIES];
    logic signed [15:0] r_bias_mem [DIMS];
    logic signed [15:0] r_hid_rd;
    logic signed [15:0] r_bias_rd;

    logic [sdrnn_pkg::DECAY_BITS-1:0] r_decay;
    logic                             r_clearing;
    logic [AW-1:0]                    r_clr_addr;

    // input decode
    logic [BI_W-1:0] in_b;
    logic [DI_W-1:0] in_d;
    logic [AW-1:0]   in_haddr;
    logic [DW-1:0]   in_daddr;
    logic            in_step;
    logic            in_ld_hid;
    logic            in_ld_bias;
    logic            conflict;
    logic            in_ready;
    logic            in_accept;
    logic [CNT_W-1:0] occ;

    // stage 1: memory read data available
    logic            r1_step, r1_wr_hid, r1_wr_bias;
    logic [BI_W-1:0] r1_b;
    logic [DI_W-1:0] r1_d;
    logic [AW-1:0]   r1_haddr;
    logic [DW-1:0]   r1_daddr;
    logic signed [15:0] r1_value;
    logic            r1_last;
    logic signed [15:0] h_prev;
    logic signed [15:0] bias_fwd;
    logic signed [16:0] sum_s1;
    logic signed [P_W-1:0] n2_prod;

    // stage 2: round, add bias, saturate, write back
    logic            r2_step, r2_wr_hid, r2_wr_bias;
    logic [BI_W-1:0] r2_b;
    logic [DI_W-1:0] r2_d;
    logic [AW-1:0]   r2_haddr;
    logic [DW-1:0]   r2_daddr;
    logic signed [15:0] r2_value;
    logic            r2_last;
    logic signed [P_W-1:0] r2_prod;
    logic signed [15:0] r2_bias;
    logic signed [P_W-1:0] rnd2;
    logic signed [19:0] hsum;
    logic            h_sat;
    logic signed [15:0] h_s2;
    logic signed [15:0] wdata_s2;

    // stage 3: written value kept for forwarding, feeds the gate pipeline
    logic            r3_step, r3_wr_hid, r3_wr_bias;
    logic [BI_W-1:0] r3_b;
    logic [DI_W-1:0] r3_d;
    logic [AW-1:0]   r3_haddr;
    logic [DW-1:0]   r3_daddr;
    logic signed [15:0] r3_wdata;
    logic            r3_sat;
    logic            r3_last;

    logic            hid_we;
    logic [AW-1:0]   hid_waddr;
    logic signed [15:0] hid_wdata;
    logic            bias_we;
    logic [DW-1:0]   bias_waddr;
    logic signed [15:0] bias_wdata;

    sdrnn_pkg::t_gate_in   gate_in;
    sdrnn_pkg::t_result    gate_res;
    sdrnn_pkg::t_gate_busy gate_busy;
    logic                  gate_valid;

    sdrnn_pkg::t_result r_fifo [FIFO_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   n_cnt;
    logic               push;
    logic               pop;

    always_comb begin
        in_b       = bat_mod[i_item.batch_index];
        in_d       = dim_mod[i_item.dim_index];
        in_haddr   = AW'(in_b) * AW'(DIMS) + AW'(in_d);
        in_daddr   = DW'(in_d);
        in_step    = i_item.operation == sdrnn_pkg::OP_STEP;
        in_ld_hid  = i_item.operation == sdrnn_pkg::OP_LOAD_HIDDEN;
        in_ld_bias = i_item.operation == sdrnn_pkg::OP_LOAD_BIAS;
        // the entry the stage 1 transaction writes is not in memory in time
        conflict   = in_step && ((r1_wr_hid && r1_haddr == in_haddr) ||
                                 (r1_wr_bias && r1_daddr == in_daddr));
        occ        = r_cnt + CNT_W'($countones({r1_step, r2_step, r3_step,
                                                gate_busy.s4, gate_busy.s5}));
        in_ready   = !r_clearing && (occ < CNT_W'(FIFO_DEPTH)) && !conflict;
        in_accept  = i_item.valid && in_ready;
    end

    assign i_item.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decay    <= sdrnn_pkg::DECAY_RESET;
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            if (i_cfg_we) begin
                r_decay <= i_cfg_wdata;
            end
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(ENTRIES - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
        end
    end

    // write port: clearing sweep or stage 2 write-back
    always_comb begin
        hid_we     = r_clearing || r2_wr_hid;
        hid_waddr  = r_clearing ? r_clr_addr : r2_haddr;
        hid_wdata  = r_clearing ? 16'sd0 : wdata_s2;
        bias_we    = (r_clearing && int'(r_clr_addr) < DIMS) || r2_wr_bias;
        bias_waddr = r_clearing ? DW'(r_clr_addr) : r2_daddr;
        bias_wdata = r_clearing ? 16'sd0 : r2_value;
    end

    always_ff @(posedge i_clk) begin
        if (hid_we) begin
            r_hid_mem[hid_waddr] <= hid_wdata;
        end
        if (in_accept) begin
            r_hid_rd <= r_hid_mem[in_haddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (bias_we) begin
            r_bias_mem[bias_waddr] <= bias_wdata;
        end
        if (in_accept) begin
            r_bias_rd <= r_bias_mem[in_daddr];
        end
    end

    // stage 1: forward what stage 3 wrote after the read was issued
    always_comb begin
        h_prev   = (r3_wr_hid && r3_haddr == r1_haddr) ? r3_wdata : r_hid_rd;
        bias_fwd = (r3_wr_bias && r3_daddr == r1_daddr) ? r3_wdata : r_bias_rd;
        sum_s1   = 17'(h_prev) + 17'(r1_value);
        n2_prod  = P_W'($signed({1'b0, r_decay})) * P_W'(sum_s1);
    end

    always_comb begin
        rnd2  = r2_prod + H_HALF - P_W'(r2_prod[P_W-1]);
        hsum  = 20'($signed(rnd2[P_W-1:15])) + 20'(r2_bias);
        h_sat = hsum[19:15] != {5{hsum[19]}};
        if (h_sat) begin
            h_s2 = hsum[19] ? 16'sh8000 : 16'sh7fff;
        end else begin
            h_s2 = hsum[15:0];
        end
        wdata_s2 = r2_step ? h_s2 : r2_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_step    <= 1'b0;
            r1_wr_hid  <= 1'b0;
            r1_wr_bias <= 1'b0;
            r2_step    <= 1'b0;
            r2_wr_hid  <= 1'b0;
            r2_wr_bias <= 1'b0;
            r3_step    <= 1'b0;
            r3_wr_hid  <= 1'b0;
            r3_wr_bias <= 1'b0;
        end else begin
            r1_step    <= in_accept && in_step;
            r1_wr_hid  <= in_accept && (in_step || in_ld_hid);
            r1_wr_bias <= in_accept && in_ld_bias;
            r2_step    <= r1_step;
            r2_wr_hid  <= r1_wr_hid;
            r2_wr_bias <= r1_wr_bias;
            r3_step    <= r2_step;
            r3_wr_hid  <= r2_wr_hid;
            r3_wr_bias <= r2_wr_bias;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_b     <= in_b;
        r1_d     <= in_d;
        r1_haddr <= in_haddr;
        r1_daddr <= in_daddr;
        r1_value <= i_item.value;
        r1_last  <= i_item.end_of_sequence;

        r2_b     <= r1_b;
        r2_d     <= r1_d;
        r2_haddr <= r1_haddr;
        r2_daddr <= r1_daddr;
        r2_value <= r1_value;
        r2_last  <= r1_last;
        r2_prod  <= n2_prod;
        r2_bias  <= bias_fwd;

        r3_b     <= r2_b;
        r3_d     <= r2_d;
        r3_haddr <= r2_haddr;
        r3_daddr <= r2_daddr;
        r3_wdata <= wdata_s2;
        r3_sat   <= h_sat;
        r3_last  <= r2_last;
    end

    always_comb begin
        gate_in.b    = r3_b;
        gate_in.d    = r3_d;
        gate_in.h    = r3_wdata;
        gate_in.sat  = r3_sat;
        gate_in.last = r3_last;
    end

    sdrnn_gate u_gate (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r3_step),
        .i_item   (gate_in),
        .o_valid  (gate_valid),
        .o_result (gate_res),
        .o_busy   (gate_busy)
    );

    // output fifo
    always_comb begin
        push  = gate_valid;
        pop   = o_result.valid && o_result.ready;
        n_cnt = r_cnt + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr_ptr] <= gate_res;
        end
    end

    assign o_result.valid     = r_cnt != '0;
    assign o_result.out_batch = r_fifo[r_rd_ptr].out_batch;
    assign o_result.out_dim   = r_fifo[r_rd_ptr].out_dim;
    assign o_result.hidden    = r_fifo[r_rd_ptr].hidden;
    assign o_result.gated     = r_fifo[r_rd_ptr].gated;
    assign o_result.saturated = r_fifo[r_rd_ptr].saturated;
    assign o_result.last      = r_fifo[r_rd_ptr].last;

`ifndef ASSERT_OFF
    a_fifo_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (r_cnt != CNT_W'(FIFO_DEPTH)) || pop)
        else $error("output fifo pushed while full");

    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (occ + CNT_W'(in_accept && in_step)) <= CNT_W'(FIFO_DEPTH))
        else $error("steps in flight exceed fifo space");

    a_no_stale_hidden: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && in_step |=> !(r2_wr_hid && r2_haddr == r1_haddr))
        else $error("step read a hidden entry with a write still pending");

    a_no_stale_bias: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && in_step |=> !(r2_wr_bias && r2_daddr == r1_daddr))
        else $error("step read a bias entry with a write still pending");

    a_clear_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !(r1_wr_hid || r1_wr_bias || r2_wr_hid || r2_wr_bias))
        else $error("pipeline write during clearing sweep");
`endif

endmodule

@@ design/sdrnn_gate.sv @@
module sdrnn_gate (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  sdrnn_pkg::t_gate_in    i_item,
    output logic                   o_valid,
    output sdrnn_pkg::t_result     o_result,
    output sdrnn_pkg::t_gate_busy  o_busy
);

    localparam int P_W = 33;
    localparam int G_W = P_W - sdrnn_pkg::FRAC_BITS;
    localparam logic signed [P_W-1:0] SIG_HALF = 33'sd16384;
    localparam logic signed [P_W-1:0] G_HALF   = 33'sd1 <<< (sdrnn_pkg::FRAC_BITS - 1);

    logic [15:0]            habs;
    logic [19:0]            mag;
    logic [15:0]            sig_pos;
    logic [15:0]            sig;
    logic signed [P_W-1:0]  n4_prod;
    logic signed [P_W-1:0]  rnd4;
    logic signed [16:0]     silu;
    logic signed [P_W-1:0]  n5_prod;
    logic signed [P_W-1:0]  rnd5;
    logic signed [G_W-1:0]  g_wide;
    logic                   g_sat;
    sdrnn_pkg::t_value      g;

    logic                   r4_valid;
    logic                   r5_valid;
    sdrnn_pkg::t_gate_in    r4_item;
    sdrnn_pkg::t_gate_in    r5_item;
    logic signed [P_W-1:0]  r4_prod;
    logic signed [P_W-1:0]  r5_prod;

    // piecewise linear sigmoid on |h| in q5.15, result in q1.15, then h * sigmoid
    always_comb begin
        habs = i_item.h[15] ? 16'(-i_item.h) : 16'(i_item.h);
        mag  = {habs, 4'b0000};
        if (mag >= 20'd163840) begin
            sig_pos = 16'd32768;
        end else if (mag >= 20'd77824) begin
            sig_pos = 16'(mag >> 5) + 16'd27648;
        end else if (mag >= 20'd32768) begin
            sig_pos = 16'(mag >> 3) + 16'd20480;
        end else begin
            sig_pos = 16'(mag >> 2) + 16'd16384;
        end
        sig     = i_item.h[15] ? (16'd32768 - sig_pos) : sig_pos;
        n4_prod = P_W'(i_item.h) * P_W'($signed({1'b0, sig}));
    end

    // round half away from zero: add half, minus one when negative, then shift
    always_comb begin
        rnd4    = r4_prod + SIG_HALF - P_W'(r4_prod[P_W-1]);
        silu    = rnd4[31:15];
        n5_prod = P_W'(r4_item.h) * P_W'(silu);
    end

    always_comb begin
        rnd5   = r5_prod + G_HALF - P_W'(r5_prod[P_W-1]);
        g_wide = rnd5[P_W-1:sdrnn_pkg::FRAC_BITS];
        g_sat  = g_wide[G_W-1:15] != {(G_W - 15){g_wide[G_W-1]}};
        if (g_sat) begin
            g = g_wide[G_W-1] ? 16'sh8000 : 16'sh7fff;
        end else begin
            g = g_wide[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
        end else begin
            r4_valid <= i_valid;
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_item <= i_item;
        r4_prod <= n4_prod;
        r5_item <= r4_item;
        r5_prod <= n5_prod;
    end

    always_comb begin
        o_valid            = r5_valid;
        o_result.out_batch = r5_item.b;
        o_result.out_dim   = r5_item.d;
        o_result.hidden    = r5_item.h;
        o_result.gated     = g;
        o_result.saturated = r5_item.sat | g_sat;
        o_result.last      = r5_item.last;
        o_busy.s4          = r4_valid;
        o_busy.s5          = r5_valid;
    end

endmodule

@@ dv/tb_scalar_decay_rnn_forward_top.sv @@
module tb_scalar_decay_rnn_forward_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BATCHES     = 4;
    localparam int DIMS        = 256;
    localparam int N_PHASES    = 6;
    localparam int PHASE_ITEMS = 160;
    localparam int DRAIN_LIMIT = 2000;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    // piecewise sigmoid breakpoints, unsigned Q5.15 on |h|, segment offsets in Q1.15
    localparam longint SIG_ONE     = 32768;
    localparam longint SIG_SAT_MIN = 5 * SIG_ONE;
    localparam longint SIG_MID_MIN = 77824;
    localparam longint SIG_HI_OFS  = 27648;
    localparam longint SIG_MID_OFS = 20480;
    localparam longint SIG_LO_OFS  = 16384;

    localparam int SRC_IDLE   [N_PHASES] = '{0, 72, 0, 10, 0, 72};
    localparam int SINK_STALL [N_PHASES] = '{0, 0, 72, 10, 72, 0};

    typedef struct packed {
        logic [1:0]  op;
        logic [1:0]  batch;
        logic [7:0]  dim;
        logic [15:0] value;
        logic        eos;
        logic        typed;
        logic [15:0] exp_hidden;
        logic [15:0] exp_gated;
        logic        exp_sat;
    } t_directed;

    localparam int N_DIRECTED = 24;

    t_directed directed_rows [N_DIRECTED] = '{
        '{sdrnn_pkg::OP_STEP, 2'd0, 8'd0, 16'h0000, 1'b0, 1'b1, 16'h0000, 16'h0000, 1'b0},
        '{sdrnn_pkg::OP_STEP, 2'd3, 8'd255, 16'h7FFF, 1'b1, 1'b1, 16'h4000, 16'h7FFF, 1'b1},
        '{sdrnn_pkg::OP_STEP, 2'd1, 8'd1, 16'h8000, 1'b0, 1'b1, 16'hC000, 16'h0000, 1'b0},
        '{sdrnn_pkg::OP_LOAD_BIAS, 2'd0, 8'd2, 16'h7FFF, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{sdrnn_pkg::OP_LOAD_HIDDEN, 2'd2, 8'd2, 16'h7FFF, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{sdrnn_pkg::OP_STEP, 2'd2, 8'd2, 16'h7FFF, 1'b0, 1'b1, 16'h7FFF, 16'h7FFF, 1'b1},
        // loads ignore the end flag
        '{sdrnn_pkg::OP_LOAD_BIAS, 2'd0, 8'd3, 16'h8000, 1'b1, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{sdrnn_pkg::OP_LOAD_HIDDEN, 2'd0, 8'd3, 16'h8000, 1'b1, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{sdrnn_pkg::OP_STEP, 2'd0, 8'd3, 16'h8000, 1'b1, 1'b1, 16'h8000, 16'h0000, 1'b1},
        // unused opcode must leave position 0,0 alone
        '{OP_UNUSED, 2'd0, 8'd0, 16'h1234, 1'b1, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{sdrnn_pkg::OP_STEP, 2'd0, 8'd0, 16'h0000, 1'b0, 1'b1, 16'h0000, 16'h0000, 1'b0},
        // sigmoid segment edges, h = x/2 here
        '{sdrnn_pkg::OP_STEP, 2'd1, 8'd4, 16'h1000, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{sdrnn_pkg::OP_STEP, 2'd1, 8'd5, 16'h0FFE, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{sdrnn_pkg::OP_STEP, 2'd1, 8'd6, 16'h2600, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{sdrnn_pkg::OP_STEP, 2'd1, 8'd7, 16'h25FE, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{sdrnn_pkg::OP_STEP, 2'd1, 8'd8, 16'h5000, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{sdrnn_pkg::OP_STEP, 2'd1, 8'd9, 16'h4FFE, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{sdrnn_pkg::OP_STEP, 2'd2, 8'd4, 16'hF000, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{sdrnn_pkg::OP_STEP, 2'd2, 8'd6, 16'hDA00, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{sdrnn_pkg::OP_STEP, 2'd2, 8'd8, 16'hB000, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        // half-lsb rounding away from zero
        '{sdrnn_pkg::OP_STEP, 2'd0, 8'd10, 16'h0001, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{sdrnn_pkg::OP_STEP, 2'd0, 8'd11, 16'hFFFF, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        // recurrence on positions stepped before
        '{sdrnn_pkg::OP_STEP, 2'd3, 8'd255, 16'h0000, 1'b1, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{sdrnn_pkg::OP_STEP, 2'd1, 8'd1, 16'h0000, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0}
    };

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [sdrnn_pkg::DECAY_BITS-1:0] i_cfg_wdata;

    sdrnn_in_if  item_if ();
    sdrnn_out_if result_if ();

    scalar_decay_rnn_forward_top #(
        .BATCHES (BATCHES),
        .DIMS    (DIMS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item_if),
        .o_result    (result_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // cell state as the block should hold it
    sdrnn_pkg::t_value hidden_mem [BATCHES*DIMS];
    sdrnn_pkg::t_value bias_mem   [DIMS];
    logic [sdrnn_pkg::DECAY_BITS-1:0] decay_q15;

    sdrnn_pkg::t_result pending_results [$];

    int src_idle_pct;
    int sink_stall_pct;
    int items_sent;
    int steps_sent;
    int results_checked;
    int saturated_seen;
    int mismatches;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic longint round_away(input longint v, input int n);
        longint half;
        half = longint'(1) <<< (n - 1);
        if (v >= 0)
            return (v + half) >>> n;
        return -((-v + half) >>> n);
    endfunction

    function automatic longint clip_value(input longint v, inout bit clipped);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (sdrnn_pkg::VALUE_BITS - 1)) - 1;
        lo = -(longint'(1) <<< (sdrnn_pkg::VALUE_BITS - 1));
        if (v > hi) begin
            clipped = 1'b1;
            return hi;
        end
        if (v < lo) begin
            clipped = 1'b1;
            return lo;
        end
        return v;
    endfunction

    function automatic longint sigmoid_pwl(input longint h);
        longint a;
        longint s;
        a = (h < 0 ? -h : h) <<< (15 - sdrnn_pkg::FRAC_BITS);
        if (a >= SIG_SAT_MIN)
            s = SIG_ONE;
        else if (a >= SIG_MID_MIN)
            s = (a >>> 5) + SIG_HI_OFS;
        else if (a >= SIG_ONE)
            s = (a >>> 3) + SIG_MID_OFS;
        else
            s = (a >>> 2) + SIG_LO_OFS;
        return (h < 0) ? SIG_ONE - s : s;
    endfunction

    // applies one transaction to the cell state, returns 1 when a result is due
    function automatic bit cell_predict(input logic [1:0] op, input logic [1:0] b,
                                        input logic [7:0] d, input logic [15:0] val,
                                        input logic eos, output sdrnn_pkg::t_result res);
        int     pos;
        int     dim;
        bit     clipped;
        longint h;
        longint silu;
        longint g;
        res = '0;
        clipped = 1'b0;
        dim = int'(d) % DIMS;
        pos = (int'(b) % BATCHES) * DIMS + dim;
        case (op)
            sdrnn_pkg::OP_LOAD_BIAS: begin
                bias_mem[dim] = sdrnn_pkg::t_value'(val);
                return 1'b0;
            end
            sdrnn_pkg::OP_LOAD_HIDDEN: begin
                hidden_mem[pos] = sdrnn_pkg::t_value'(val);
                return 1'b0;
            end
            sdrnn_pkg::OP_STEP: begin
                h = round_away(longint'(decay_q15) *
                               (longint'(sdrnn_pkg::t_value'(val)) +
                                longint'(hidden_mem[pos])), 15);
                h = clip_value(h + longint'(bias_mem[dim]), clipped);
                hidden_mem[pos] = sdrnn_pkg::t_value'(h);
                silu = round_away(h * sigmoid_pwl(h), 15);
                g = clip_value(round_away(h * silu, sdrnn_pkg::FRAC_BITS), clipped);
                res.out_batch = b;
                res.out_dim   = d;
                res.hidden    = sdrnn_pkg::t_value'(h);
                res.gated     = sdrnn_pkg::t_value'(g);
                res.saturated = clipped;
                res.last      = eos;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [15:0] pick_value();
        case ($urandom_range(9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2, 3, 4: return 16'($urandom_range(8191)) - 16'd4096;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_item(input logic [1:0] op, input logic [1:0] b, input logic [7:0] d,
                             input logic [15:0] val, input logic eos,
                             input bit use_typed = 1'b0,
                             input sdrnn_pkg::t_result typed_res = '0);
        sdrnn_pkg::t_result predicted;
        bit                 makes_result;
        while ($urandom_range(99) < src_idle_pct)
            @(negedge i_clk);
        item_if.valid           = 1'b1;
        item_if.operation       = op;
        item_if.batch_index     = b;
        item_if.dim_index       = d;
        item_if.value           = val;
        item_if.end_of_sequence = eos;
        do @(posedge i_clk); while (item_if.ready !== 1'b1);
        makes_result = cell_predict(op, b, d, val, eos, predicted);
        if (makes_result)
            pending_results.push_back(use_typed ? typed_res : predicted);
        if (op != OP_UNUSED)
            items_sent++;
        if (op == sdrnn_pkg::OP_STEP)
            steps_sent++;
        @(negedge i_clk);
        item_if.valid = 1'b0;
    endtask

    // biases, optional initial hidden values, then time steps over every batch row
    task automatic run_sequence();
        logic [7:0] base;
        int         n_dims;
        int         n_steps;
        int         cut;
        int         k;
        logic       eos;
        base    = 8'($urandom_range(255));
        n_dims  = $urandom_range(1, 6);
        n_steps = $urandom_range(1, 4);
        // one sequence in ten is broken off early
        cut = ($urandom_range(9) == 0) ? $urandom_range(n_dims * BATCHES * n_steps - 1) : -1;
        k = 0;
        for (int j = 0; j < n_dims; j++)
            send_item(sdrnn_pkg::OP_LOAD_BIAS, 2'($urandom_range(3)), 8'(base + j),
                      pick_value(), 1'($urandom_range(1)));
        for (int b = 0; b < BATCHES; b++)
            for (int j = 0; j < n_dims; j++)
                if ($urandom_range(1) == 1)
                    send_item(sdrnn_pkg::OP_LOAD_HIDDEN, 2'(b), 8'(base + j), pick_value(),
                              1'b0);
        for (int t = 0; t < n_steps; t++)
            for (int b = 0; b < BATCHES; b++)
                for (int j = 0; j < n_dims; j++) begin
                    if (k == cut)
                        return;
                    eos = (t == n_steps - 1) && (b == BATCHES - 1) && (j == n_dims - 1);
                    send_item(sdrnn_pkg::OP_STEP, 2'(b), 8'(base + j), pick_value(), eos);
                    k++;
                end
    endtask

    task automatic write_decay(input logic [sdrnn_pkg::DECAY_BITS-1:0] v);
        while (pending_results.size() != 0)
            @(posedge i_clk);
        // loads may still be in the pipe
        repeat (8) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = v;
        @(posedge i_clk);
        decay_q15 = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    initial begin
        result_if.ready = 1'b1;
        forever begin
            @(negedge i_clk);
            result_if.ready = ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin : result_check
        sdrnn_pkg::t_result got;
        sdrnn_pkg::t_result want;
        if (i_rst_n && result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
            got.out_batch = result_if.out_batch;
            got.out_dim   = result_if.out_dim;
            got.hidden    = result_if.hidden;
            got.gated     = result_if.gated;
            got.saturated = result_if.saturated;
            got.last      = result_if.last;
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: expected no result, actual b=%0d d=%0d h=%0d g=%0d sat=%0b last=%0b",
                         $time, got.out_batch, got.out_dim, got.hidden, got.gated,
                         got.saturated, got.last);
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (got.saturated)
                    saturated_seen++;
                if (got !== want) begin
                    mismatches++;
                    $display("%0t: expected b=%0d d=%0d h=%0d g=%0d sat=%0b last=%0b",
                             $time, want.out_batch, want.out_dim, want.hidden,
                             want.gated, want.saturated, want.last);
                    $display("%0t:   actual b=%0d d=%0d h=%0d g=%0d sat=%0b last=%0b",
                             $time, got.out_batch, got.out_dim, got.hidden, got.gated,
                             got.saturated, got.last);
                end
            end
        end
    end

    initial begin
        t_directed          row;
        sdrnn_pkg::t_result typed_res;
        logic [sdrnn_pkg::DECAY_BITS-1:0] phase_decay [N_PHASES];
        int                 phase_target;

        item_if.valid           = 1'b0;
        item_if.operation       = sdrnn_pkg::OP_LOAD_BIAS;
        item_if.batch_index     = '0;
        item_if.dim_index       = '0;
        item_if.value           = '0;
        item_if.end_of_sequence = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        i_rst_n        = 1'b0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        items_sent     = 0;
        steps_sent     = 0;
        results_checked = 0;
        saturated_seen = 0;
        mismatches     = 0;
        decay_q15      = sdrnn_pkg::DECAY_RESET;
        foreach (hidden_mem[i]) hidden_mem[i] = '0;
        foreach (bias_mem[i]) bias_mem[i] = '0;

        phase_decay = '{16'd0, 16'd32768, 16'hFFFF, 16'd1, 16'($urandom),
                        sdrnn_pkg::DECAY_RESET};

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int i = 0; i < N_DIRECTED; i++) begin
            row = directed_rows[i];
            typed_res.out_batch = row.batch;
            typed_res.out_dim   = row.dim;
            typed_res.hidden    = sdrnn_pkg::t_value'(row.exp_hidden);
            typed_res.gated     = sdrnn_pkg::t_value'(row.exp_gated);
            typed_res.saturated = row.exp_sat;
            typed_res.last      = row.eos;
            send_item(row.op, row.batch, row.dim, row.value, row.eos, row.typed, typed_res);
        end

        for (int p = 0; p < N_PHASES; p++) begin
            write_decay(phase_decay[p]);
            src_idle_pct   = SRC_IDLE[p];
            sink_stall_pct = SINK_STALL[p];
            phase_target   = items_sent + PHASE_ITEMS;
            while (items_sent < phase_target) begin
                if ($urandom_range(99) < 15)
                    send_item(2'($urandom_range(3)), 2'($urandom_range(3)), 8'($urandom),
                              pick_value(), 1'($urandom_range(1)));
                else
                    run_sequence();
            end
        end

        sink_stall_pct = 0;
        for (int w = 0; w < DRAIN_LIMIT && pending_results.size() != 0; w++)
            @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, pending_results.size());
            mismatches += pending_results.size();
        end
        repeat (20) @(posedge i_clk);

        $display("covered %0d transactions (%0d steps), %0d results checked, %0d saturated",
                 items_sent, steps_sent, results_checked, saturated_seen);
        $display("decay swept from 0 to full scale over %0d settings under four idle mixes",
                 N_PHASES);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("%0t: timeout", $time);
        $display("Some tests failed");
        $finish;
    end

endmodule

@@ filelist.f @@
design/sdrnn_pkg.sv
design/sdrnn_if.sv
design/sdrnn_gate.sv
design/scalar_decay_rnn_forward_top.sv
dv/tb_scalar_decay_rnn_forward_top.sv
